[rtl/core/ipv4_lpm_pkg.sv]
// Shared types and codes for the IPv4 longest-prefix-match unit.
// No dependencies; imported by the route table and the top level.
`timescale 1ns / 1ps

package ipv4_lpm_pkg;

  localparam int unsigned AddrW    = 32;
  localparam int unsigned PortW    = 8;
  localparam int unsigned LenW     = 6;
  localparam int unsigned StatusW  = 3;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 8;

  // Operation codes
  localparam logic FUNC_ADD    = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  // Result status codes
  localparam logic [StatusW-1:0] ST_ADDED   = 3'd0;
  localparam logic [StatusW-1:0] ST_FULL    = 3'd1;
  localparam logic [StatusW-1:0] ST_MATCHED = 3'd2;
  localparam logic [StatusW-1:0] ST_DEFAULT = 3'd3;
  localparam logic [StatusW-1:0] ST_NO_PATH = 3'd4;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_DEFAULT_VALID = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_DEFAULT_PORT  = 1'd1;

  typedef struct packed {
    logic             func;
    logic [AddrW-1:0] address;
    logic [AddrW-1:0] mask;
    logic [PortW-1:0] port;
  } item_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [PortW-1:0]   out_port;
  } result_t;

  typedef struct packed {
    logic [AddrW-1:0] base;
    logic [AddrW-1:0] top;
    logic [LenW-1:0]  length;
    logic [PortW-1:0] port;
  } route_t;

endpackage

[rtl/core/ipv4_lpm_table.sv]
// Route storage for the IPv4 longest-prefix-match unit: one write port,
// one registered read port. Depends on ipv4_lpm_pkg.
`timescale 1ns / 1ps

module ipv4_lpm_table #(
  parameter int unsigned TABLE_DEPTH = 16,
  parameter int unsigned IdxW        = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [IdxW-1:0]       waddr_i,
  input  ipv4_lpm_pkg::route_t  wdata_i,
  input  logic [IdxW-1:0]       raddr_i,
  output ipv4_lpm_pkg::route_t  rdata_o
);
  import ipv4_lpm_pkg::*;

  route_t mem_q [TABLE_DEPTH];
  route_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/ipv4_longest_prefix_match_unit.sv]
// IPv4 longest-prefix-match unit. Add: four mask-octet popcount steps, then one
// table write, then the result strobe; full table: the strobe follows in the cycle after start.
// Lookup: the scan runs over the stored routes through the
// single table read port, scanning one entry per cycle through one shared
// octet-range comparator. One item at a time; busy is high until the strobe.
// No output stall. Async active-low reset empties the table and clears the default route.
`timescale 1ns / 1ps

module ipv4_longest_prefix_match_unit #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start,
  output logic                                  busy,
  input  ipv4_lpm_pkg::item_t                   item_i,
  output logic                                  done_o,
  output ipv4_lpm_pkg::result_t                 result_o,
  input  logic                                  cfg_we_i,
  input  logic [ipv4_lpm_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [ipv4_lpm_pkg::CfgDataW-1:0]     cfg_data_i
);
  import ipv4_lpm_pkg::*;

  localparam int unsigned IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_POP   = 2'd1;
  localparam logic [1:0] S_WRITE = 2'd2;
  localparam logic [1:0] S_SCAN  = 2'd3;

  function automatic logic [3:0] pop8(input logic [7:0] v);
    logic [3:0] n;
    n = '0;
    for (int k = 0; k < 8; k++) begin
      n = n + {3'b0, v[k]};
    end
    return n;
  endfunction

  logic [1:0]      state_q, state_d;
  logic [1:0]      step_q, step_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] scan_q, scan_d;
  logic            rdv_q, rdv_d;
  logic            done_q, done_d;
  item_t           item_q;
  logic            item_ld;
  logic [LenW-1:0] len_q, len_d;
  logic [LenW-1:0] best_len_q, best_len_d;
  logic [PortW-1:0] best_port_q, best_port_d;
  result_t         res_q, res_d;
  logic            dflt_valid_q;
  logic [PortW-1:0] dflt_port_q;

  logic            accept;
  logic            tbl_we;
  route_t          tbl_wdata;
  route_t          tbl_rdata;
  logic            rd_en;
  logic            hit;
  logic [AddrW-1:0] top_shift;
  logic [7:0]      mask_octet;
  result_t         fallback;

  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);

  ipv4_lpm_table #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .IdxW        (IdxW)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (count_q[IdxW-1:0]),
    .wdata_i (tbl_wdata),
    .raddr_i (scan_q[IdxW-1:0]),
    .rdata_o (tbl_rdata)
  );

  // Shared comparator: every address octet within the entry's bounds
  always_comb begin
    hit = 1'b1;
    for (int k = 0; k < 4; k++) begin
      if (item_q.address[8*k +: 8] < tbl_rdata.base[8*k +: 8] ||
          item_q.address[8*k +: 8] > tbl_rdata.top[8*k +: 8]) begin
        hit = 1'b0;
      end
    end
  end

  assign mask_octet = item_q.mask[{step_q, 3'b000} +: 8];
  // A shift by the full width clears everything, so a zero length sets all bits
  assign top_shift  = {AddrW{1'b1}} << (LenW'(AddrW) - len_q);

  always_comb begin
    tbl_wdata.base   = item_q.address;
    tbl_wdata.top    = item_q.address | ~top_shift;
    tbl_wdata.length = len_q;
    tbl_wdata.port   = item_q.port;
  end

  always_comb begin
    priority if (best_len_q != '0) begin
      fallback.status   = ST_MATCHED;
      fallback.out_port = best_port_q;
    end else if (dflt_valid_q) begin
      fallback.status   = ST_DEFAULT;
      fallback.out_port = dflt_port_q;
    end else begin
      fallback.status   = ST_NO_PATH;
      fallback.out_port = '0;
    end
  end

  assign rd_en = (scan_q != count_q);

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    count_d     = count_q;
    scan_d      = scan_q;
    rdv_d       = 1'b0;
    done_d      = 1'b0;
    len_d       = len_q;
    best_len_d  = best_len_q;
    best_port_d = best_port_q;
    res_d       = res_q;
    item_ld     = 1'b0;
    tbl_we      = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          item_ld = 1'b1;
          if (item_i.func == FUNC_LOOKUP) begin
            scan_d     = '0;
            best_len_d = '0;
            state_d    = S_SCAN;
          end else if (count_q == CntW'(TABLE_DEPTH)) begin
            // Drop the add and report at once
            res_d.status   = ST_FULL;
            res_d.out_port = '0;
            done_d         = 1'b1;
          end else begin
            step_d  = '0;
            len_d   = '0;
            state_d = S_POP;
          end
        end
      end
      S_POP: begin
        len_d  = len_q + LenW'(pop8(mask_octet));
        step_d = step_q + 2'd1;
        if (step_q == 2'd3) begin
          state_d = S_WRITE;
        end
      end
      S_WRITE: begin
        tbl_we         = 1'b1;
        count_d        = count_q + CntW'(1);
        res_d.status   = ST_ADDED;
        res_d.out_port = '0;
        done_d         = 1'b1;
        state_d        = S_IDLE;
      end
      S_SCAN: begin
        if (rd_en) begin
          scan_d = scan_q + CntW'(1);
          rdv_d  = 1'b1;
        end
        // Strictly longer wins, so the earliest entry keeps a tie
        if (rdv_q && hit && tbl_rdata.length > best_len_q) begin
          best_len_d  = tbl_rdata.length;
          best_port_d = tbl_rdata.port;
        end
        if (!rd_en && !rdv_q) begin
          res_d   = fallback;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
      count_q <= '0;
      scan_q  <= '0;
      rdv_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      count_q <= count_d;
      scan_q  <= scan_d;
      rdv_q   <= rdv_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_ld) begin
      item_q <= item_i;
    end
    len_q       <= len_d;
    best_len_q  <= best_len_d;
    best_port_q <= best_port_d;
    res_q       <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dflt_valid_q <= 1'b0;
      dflt_port_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DEFAULT_VALID: dflt_valid_q <= cfg_data_i[0];
        CFG_DEFAULT_PORT:  dflt_port_q  <= cfg_data_i[PortW-1:0];
        default: begin
        end
      endcase
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

`ifndef SYNTHESIS
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(TABLE_DEPTH))
    else $error("route count beyond table depth");

  a_accept_progress : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (busy || done_o))
    else $error("accepted transfer neither in flight nor answered");

  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while still busy");

  a_status_code : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (result_o.status == ST_ADDED || result_o.status == ST_FULL ||
                result_o.status == ST_MATCHED || result_o.status == ST_DEFAULT ||
                result_o.status == ST_NO_PATH))
    else $error("undefined status code");

  a_scan_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (scan_q <= count_q))
    else $error("scan pointer ran past stored routes");
`endif

endmodule
